// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int KEY_PORT_W  = 32;
	localparam int VALUE_W     = 32;
	localparam int CAP_W       = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_kind_t;

	typedef enum logic {
		ST_LOOKUP = 1'b0,
		ST_UPDATE = 1'b1
	} eng_state_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [KEY_PORT_W-1:0] key;
		logic [VALUE_W-1:0]    value;
	} op_t;

endpackage

// ----- rtl/lkv_ram.sv -----
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/lkv_front.sv -----
// ----------------------------------------------------------------------------
// lkv_front
// Input side: takes transactions, tags them as get or put and queues them
// for the lookup engine.
// ----------------------------------------------------------------------------
module lkv_front import lkv_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [KEY_PORT_W-1:0]        key,
	input  logic signed [VALUE_W-1:0]    value,
	output logic                         op_valid,
	output op_t                          op,
	input  logic                         op_pop
);

	op_t                    slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] head_q;
	logic [QUEUE_PTR_W-1:0] tail_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	op_t                    op_in;

	assign in_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign op_valid = (count_q != '0);
	assign op       = slot_q[head_q];

	always_comb begin
		op_in.kind  = op_kind_t'(kind);
		op_in.key   = key;
		op_in.value = value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (op_pop) begin
				head_q <= (head_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			unique case ({push, op_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/lkv_engine.sv -----
// ----------------------------------------------------------------------------
// lkv_engine
// Back end: parallel tag compare and victim pick in the lookup cycle,
// recency rank update, key/value write and result load in the update cycle.
// ----------------------------------------------------------------------------
module lkv_engine import lkv_pkg::*; #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CAP_W-1:0]          cap,
	input  logic                      op_valid,
	input  op_t                       op,
	output logic                      op_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic signed [VALUE_W-1:0] value_out
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int TAG_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [TAG_W-1:0] key_q  [ENTRIES];
	logic [IDX_W-1:0] rank_q [ENTRIES];
	logic [CNT_W-1:0] fill_q;

	eng_state_t state_q;
	eng_state_t state_d;
	logic       advance;
	logic       out_free;

	logic [TAG_W-1:0]   tag;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] oldest;
	logic [CNT_W-1:0]   last_rank;
	logic [IDX_W-1:0]   hit_slot;
	logic [IDX_W-1:0]   hit_rank;
	logic [IDX_W-1:0]   old_slot;
	logic               found;
	logic [CMP_W-1:0]   cap_w;
	logic [CMP_W-1:0]   eff_cap;
	logic               filling;
	logic [IDX_W-1:0]   tgt_slot;
	logic [IDX_W-1:0]   tgt_rank;

	op_kind_t           kind_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               found_s1;
	logic               fill_s1;
	logic               promote_s1;
	logic [IDX_W-1:0]   slot_s1;
	logic [IDX_W-1:0]   rank_s1;

	logic [VALUE_W-1:0] rd_value;
	logic               out_valid_q;
	logic               hit_q;
	logic [VALUE_W-1:0] value_q;

	// lookup: compare against every valid entry, find the oldest one
	assign tag       = op.key[TAG_W-1:0];
	assign last_rank = fill_q - CNT_W'(1);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = (CNT_W'(i) < fill_q) && (key_q[i] == tag);
			oldest[i] = (CNT_W'(i) < fill_q) && (rank_q[i] == last_rank[IDX_W-1:0]);
		end
	end

	always_comb begin
		hit_slot = '0;
		hit_rank = '0;
		old_slot = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_slot = IDX_W'(i);
				hit_rank = rank_q[i];
			end
			if (oldest[i]) begin
				old_slot = IDX_W'(i);
			end
		end
	end

	assign found = |match;

	// zero capacity acts as one, anything above the entry count saturates
	assign cap_w = CMP_W'(cap);

	always_comb begin
		if (cap == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_w > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_w;
		end
	end

	assign filling = (CMP_W'(fill_q) < eff_cap);

	// a fill promotes from rank fill_q, an eviction from the oldest rank
	always_comb begin
		if (found) begin
			tgt_slot = hit_slot;
			tgt_rank = hit_rank;
		end else if (filling) begin
			tgt_slot = fill_q[IDX_W-1:0];
			tgt_rank = fill_q[IDX_W-1:0];
		end else begin
			tgt_slot = old_slot;
			tgt_rank = last_rank[IDX_W-1:0];
		end
	end

	// sequencer
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (state_q)
			ST_LOOKUP: state_d = op_valid ? ST_UPDATE : ST_LOOKUP;
			ST_UPDATE: state_d = out_free ? ST_LOOKUP : ST_UPDATE;
			default:   state_d = ST_LOOKUP;
		endcase
	end

	always_comb begin
		op_pop  = 1'b0;
		advance = 1'b0;
		unique case (state_q)
			ST_LOOKUP: op_pop  = op_valid;
			ST_UPDATE: advance = out_free;
			default: begin
				op_pop  = 1'b0;
				advance = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOOKUP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			kind_s1    <= op.kind;
			tag_s1     <= tag;
			value_s1   <= op.value;
			found_s1   <= found;
			fill_s1    <= (op.kind == OP_PUT) && !found && filling;
			promote_s1 <= found || (op.kind == OP_PUT);
			slot_s1    <= tgt_slot;
			rank_s1    <= tgt_rank;
		end
	end

	// update: age every valid entry more recent than the promoted one
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (promote_s1) begin
					if (IDX_W'(i) == slot_s1) begin
						rank_q[i] <= '0;
					end else if ((CNT_W'(i) < fill_q) && (rank_q[i] < rank_s1)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
			if (kind_s1 == OP_PUT && !found_s1) begin
				key_q[slot_s1] <= tag_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (advance && fill_s1) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	lkv_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(ENTRIES)
	) u_values (
		.clk  (clk),
		.we   (advance && (kind_s1 == OP_PUT)),
		.waddr(slot_s1),
		.wdata(value_s1),
		.re   (op_pop),
		.raddr(hit_slot),
		.rdata(rd_value)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q <= found_s1;
			if (kind_s1 == OP_PUT) begin
				value_q <= value_s1;
			end else if (found_s1) begin
				value_q <= rd_value;
			end else begin
				value_q <= MISS_VALUE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign value_out = value_q;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries kind, key and value; kind selects
// get or put. Output channel (out_valid/out_ready) returns one transaction per
// input: hit and value_out (stored value on a get hit, -1 on a get miss, the
// put value echoed back on a put).
// An accepted transaction enters a two-entry queue. The engine pops one entry,
// does the tag compare and victim pick over all entries in its lookup state and
// the rank update and writes in its update state, then takes the next entry.
// A stalled receiver holds the result in the output register; the engine then
// waits in its update cycle and the queue keeps taking items until full.
// cfg_we writes the capacity (cfg_wdata) at once; write it only while idle.
// Reset empties the cache, clears the queue and sets capacity to 16; stored
// keys and values are not cleared, the fill count marks which are live.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CAP_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [KEY_PORT_W-1:0]     key,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic signed [VALUE_W-1:0] value_out
);

	logic [CAP_W-1:0] cap_q;
	logic             op_valid;
	op_t              op;
	logic             op_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	lkv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind    (kind),
		.key     (key),
		.value   (value),
		.op_valid(op_valid),
		.op      (op),
		.op_pop  (op_pop)
	);

	lkv_engine #(
		.ENTRIES (ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cap      (cap_q),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit),
		.value_out(value_out)
	);

endmodule

// ----- rtl/lkv_checker.sv -----
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker import lkv_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      hit,
	input logic signed [VALUE_W-1:0] value_out
);

	// queue, engine stage and result register
	localparam int MAX_OUT = QUEUE_DEPTH + 2;

	logic [2:0] outstanding_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// count transactions taken but not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			unique case ({in_xfer, out_xfer})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(value_out))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 3'd0)
		else $error("result without a pending transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'(MAX_OUT))
		else $error("more transactions in flight than storage allows");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> outstanding_q >= 3'(QUEUE_DEPTH))
		else $error("input stalled with room in the queue");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
